>>> rtl/gasp_pkg.sv
// Package for the grid path search block: sizes, request codes and payload structs.
// Used by grid_astar_path_search; depends on nothing.
package gasp_pkg;
  localparam int MaxCols   = 32;
  localparam int MaxRows   = 32;
  localparam int StepLimit = 500;
  localparam int Cells     = MaxCols * MaxRows;
  localparam int ColW      = $clog2(MaxCols);
  localparam int RowW      = $clog2(MaxRows);
  localparam int CellW     = ColW + RowW;
  localparam int LenW      = CellW + 1;
  localparam int StepW     = $clog2(StepLimit + 1);

  localparam logic [1:0] ReqWrite = 2'd0;
  localparam logic [1:0] ReqSearch = 2'd1;
  localparam logic [1:0] ReqRead = 2'd2;
  localparam logic [1:0] ReqSpare = 2'd3;

  localparam logic [1:0] DirUp = 2'd0;
  localparam logic [1:0] DirLeft = 2'd1;
  localparam logic [1:0] DirDown = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  localparam logic [0:0] CfgCols = 1'b0;
  localparam logic [0:0] CfgRows = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] tile_col;
    logic [4:0] tile_row;
    logic       tile_blocked;
    logic [4:0] start_col;
    logic [4:0] start_row;
    logic [4:0] goal_col;
    logic [4:0] goal_row;
    logic [9:0] path_index;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [10:0] path_length;
    logic [4:0]  path_col;
    logic [4:0]  path_row;
  } rsp_t;
endpackage

>>> rtl/gasp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module gasp_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/grid_astar_path_search.sv
// Grid path search: top level with sequencer, cell memories and result register.
// Depends on gasp_pkg and gasp_ram.
//
// Use: configuration writes (cfg_we, cfg_index, cfg_data) set the active grid columns
// (index 0) and rows (index 1); the user must write them only while the block is idle,
// and the block itself does not enforce this. Requests arrive on in_valid / in_ready
// with a req_t payload; every request gives one rsp_t transfer on out_valid /
// out_ready. A tile write reads the cell and then writes it; a path read reads the
// path memory. A search first sweeps the cell memory, then for each expansion scans
// all 1024 cells through the read port of the cell memory, then makes four neighbour
// updates; a found path is traced back one cell at a time. After reset the block
// clears the blocked map before the first request is taken. The result is held in an
// output register until taken; while the receiver stalls no new request is accepted.
module grid_astar_path_search
  import gasp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output rsp_t       out_data
);
  // Cell word: blocked, open, checked, parent direction, open order.
  typedef struct packed {
    logic       blk;
    logic       opn;
    logic       chk;
    logic [1:0] dir;
    logic [9:0] ord;
  } cell_t;
  localparam int CellBits = $bits(cell_t);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_TWR_RD, S_TWR_WR, S_PRD_RD, S_PRD_WAIT,
    S_CLR, S_SEED_RD, S_SEED_WR, S_SCAN, S_SCAN_LAST, S_CHK_RD, S_CHK_WR,
    S_NB_RD, S_NB_WAIT, S_NB_WR, S_TR_RD, S_TR_WAIT, S_RESP
  } state_t;

  state_t state;
  logic [5:0] cols_reg, rows_reg;
  logic [ColW:0] cols;
  logic [RowW:0] rows;
  req_t req;
  logic found_flag;
  logic [LenW-1:0] stored_len;
  logic [CellW-1:0] cnt;
  logic [CellW-1:0] cur;
  logic [9:0] order;
  logic [StepW-1:0] steps;
  logic [1:0] nd;
  logic best_v;
  logic [CellW-1:0] best;
  logic [6:0] bf, bg;
  logic [9:0] bo;
  logic [LenW-1:0] plen;

  logic cwe;
  logic [CellW-1:0] cwaddr, craddr;
  cell_t cwdata, crdata;
  logic pwe;
  logic [CellW-1:0] pwaddr, praddr, prdata;

  gasp_ram #(.Width(CellBits), .Depth(Cells)) u_cell (
    .clk(clk), .we(cwe), .waddr(cwaddr), .wdata(cwdata), .raddr(craddr), .rdata(crdata)
  );
  gasp_ram #(.Width(CellW), .Depth(Cells)) u_path (
    .clk(clk), .we(pwe), .waddr(pwaddr), .wdata(cur), .raddr(praddr), .rdata(prdata)
  );

  always_comb begin
    if (cols_reg == 6'd0) cols = (ColW+1)'(1);
    else if (cols_reg > 6'(MaxCols)) cols = (ColW+1)'(MaxCols);
    else cols = (ColW+1)'(cols_reg);
    if (rows_reg == 6'd0) rows = (RowW+1)'(1);
    else if (rows_reg > 6'(MaxRows)) rows = (RowW+1)'(MaxRows);
    else rows = (RowW+1)'(rows_reg);
  end

  // Scan candidate: the cell whose data arrives this cycle is cnt - 1.
  logic [CellW-1:0] sc_cell;
  logic [ColW-1:0] sc_c;
  logic [RowW-1:0] sc_r;
  logic [6:0] cg, cf;
  logic sc_take;
  function automatic logic [5:0] adiff(input logic [4:0] a, input logic [4:0] b);
    adiff = (a > b) ? 6'(a - b) : 6'(b - a);
  endfunction
  always_comb begin
    sc_cell = cnt - CellW'(1);
    sc_c = sc_cell[ColW-1:0];
    sc_r = sc_cell[CellW-1:ColW];
    cg = 7'(adiff(5'(sc_c), req.start_col)) + 7'(adiff(5'(sc_r), req.start_row));
    cf = cg + 7'(adiff(5'(sc_c), req.goal_col)) + 7'(adiff(5'(sc_r), req.goal_row));
    sc_take = crdata.opn && !crdata.chk && ((ColW+1)'(sc_c) < cols) &&
              ((RowW+1)'(sc_r) < rows) &&
              (!best_v || cf < bf || (cf == bf && (cg < bg || (cg == bg && crdata.ord < bo))));
  end

  // Neighbour of cur in direction nd.
  logic [ColW-1:0] cur_c;
  logic [RowW-1:0] cur_r;
  logic nb_ok;
  logic [CellW-1:0] nb;
  always_comb begin
    cur_c = cur[ColW-1:0];
    cur_r = cur[CellW-1:ColW];
    nb_ok = 1'b0;
    nb = cur;
    case (nd)
      DirUp: begin
        nb_ok = cur_r != '0;
        nb = {cur_r - RowW'(1), cur_c};
      end
      DirLeft: begin
        nb_ok = cur_c != '0;
        nb = {cur_r, cur_c - ColW'(1)};
      end
      DirDown: begin
        nb_ok = (RowW+1)'(cur_r) + (RowW+1)'(1) < rows;
        nb = {cur_r + RowW'(1), cur_c};
      end
      DirRight: begin
        nb_ok = (ColW+1)'(cur_c) + (ColW+1)'(1) < cols;
        nb = {cur_r, cur_c + ColW'(1)};
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  // Parent of cur: step against its stored direction.
  logic [CellW-1:0] par;
  always_comb begin
    case (crdata.dir)
      DirUp: par = {cur_r + RowW'(1), cur_c};
      DirLeft: par = {cur_r, cur_c + ColW'(1)};
      DirDown: par = {cur_r - RowW'(1), cur_c};
      default: par = {cur_r, cur_c - ColW'(1)};
    endcase
  end

  logic [CellW-1:0] s_cell, g_cell;
  assign s_cell = {RowW'(req.start_row), ColW'(req.start_col)};
  assign g_cell = {RowW'(req.goal_row), ColW'(req.goal_col)};

  always_comb begin
    cwe = 1'b0;
    cwaddr = cur;
    cwdata = crdata;
    craddr = cur;
    pwe = 1'b0;
    pwaddr = plen[CellW-1:0];
    praddr = req.path_index[CellW-1:0];
    case (state)
      S_INIT: begin
        cwe = 1'b1;
        cwaddr = cnt;
        cwdata = '0;
      end
      S_TWR_RD: craddr = {RowW'(req.tile_row), ColW'(req.tile_col)};
      S_TWR_WR: begin
        cwe = 1'b1;
        cwaddr = {RowW'(req.tile_row), ColW'(req.tile_col)};
        cwdata.blk = req.tile_blocked;
      end
      S_CLR: begin
        craddr = cnt;
        cwaddr = cnt - CellW'(1);
        cwe = cnt != '0;
        cwdata.opn = 1'b0;
        cwdata.chk = 1'b0;
      end
      S_SEED_RD: begin
        craddr = s_cell;
        cwaddr = cnt - CellW'(1);
        cwe = 1'b1;
        cwdata.opn = 1'b0;
        cwdata.chk = 1'b0;
      end
      S_SEED_WR: begin
        cwe = 1'b1;
        cwaddr = s_cell;
        cwdata.opn = 1'b1;
        cwdata.chk = 1'b0;
        cwdata.ord = '0;
      end
      S_SCAN: craddr = cnt;
      S_CHK_RD: craddr = best;
      S_CHK_WR: begin
        cwe = 1'b1;
        cwaddr = cur;
        cwdata.chk = 1'b1;
      end
      S_NB_RD, S_NB_WAIT: craddr = nb;
      S_NB_WR: begin
        cwe = nb_ok && !crdata.opn && !crdata.chk && !crdata.blk;
        cwaddr = nb;
        cwdata.opn = 1'b1;
        cwdata.dir = nd;
        cwdata.ord = order;
      end
      S_TR_RD: craddr = cur;
      S_TR_WAIT: begin
        pwe = 1'b1;
        craddr = cur;
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt <= '0;
      cols_reg <= 6'd32;
      rows_reg <= 6'd32;
      found_flag <= 1'b0;
      stored_len <= '0;
      out_valid <= 1'b0;
      best_v <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgCols) cols_reg <= cfg_data;
        else rows_reg <= cfg_data;
      end
      case (state)
        S_INIT: begin
          cnt <= cnt + CellW'(1);
          if (cnt == CellW'(Cells - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            out_data.path_col <= '0;
            out_data.path_row <= '0;
            case (in_data.req_type)
              ReqWrite: state <= S_TWR_RD;
              ReqSearch: begin
                found_flag <= 1'b0;
                stored_len <= '0;
                cnt <= '0;
                state <= S_CLR;
              end
              ReqRead: state <= S_PRD_RD;
              default: state <= S_RESP;
            endcase
          end
        end
        S_TWR_RD: state <= S_TWR_WR;
        S_TWR_WR: state <= S_RESP;
        S_PRD_RD: state <= S_PRD_WAIT;
        S_PRD_WAIT: begin
          if (LenW'(req.path_index) < stored_len) begin
            out_data.path_col <= 5'(prdata[ColW-1:0]);
            out_data.path_row <= 5'(prdata[CellW-1:ColW]);
          end
          state <= S_RESP;
        end
        S_CLR: begin
          cnt <= cnt + CellW'(1);
          if (cnt == CellW'(Cells - 1)) state <= S_SEED_RD;
        end
        S_SEED_RD: begin
          cnt <= '0;
          if (6'(req.start_col) >= 6'(cols) || 6'(req.start_row) >= 6'(rows) ||
              6'(req.goal_col) >= 6'(cols) || 6'(req.goal_row) >= 6'(rows)) begin
            state <= S_RESP;
          end else begin
            cur <= s_cell;
            state <= S_SEED_WR;
          end
        end
        S_SEED_WR: begin
          order <= 10'd1;
          steps <= '0;
          best_v <= 1'b0;
          cnt <= '0;
          state <= S_SCAN;
        end
        S_SCAN, S_SCAN_LAST: begin
          if (cnt != '0 || state == S_SCAN_LAST) begin
            if (sc_take) begin
              best_v <= 1'b1;
              best <= sc_cell;
              bf <= cf;
              bg <= cg;
              bo <= crdata.ord;
            end
          end
          if (state == S_SCAN) begin
            cnt <= cnt + CellW'(1);
            if (cnt == CellW'(Cells - 1)) state <= S_SCAN_LAST;
          end else begin
            state <= S_CHK_RD;
          end
        end
        S_CHK_RD: begin
          cur <= best;
          if (!best_v) begin
            state <= S_RESP;
          end else if (best == g_cell) begin
            found_flag <= 1'b1;
            plen <= '0;
            state <= S_TR_RD;
          end else if (steps >= StepW'(StepLimit)) begin
            state <= S_RESP;
          end else begin
            state <= S_CHK_WR;
          end
        end
        S_CHK_WR: begin
          nd <= DirUp;
          state <= S_NB_RD;
        end
        S_NB_RD: state <= S_NB_WAIT;
        S_NB_WAIT: state <= S_NB_WR;
        S_NB_WR: begin
          if (cwe) order <= order + 10'd1;
          if (nd == DirRight) begin
            steps <= steps + StepW'(1);
            best_v <= 1'b0;
            cnt <= '0;
            state <= S_SCAN;
          end else begin
            state <= S_NB_RD;
          end
          nd <= nd + 2'd1;
        end
        S_TR_RD: begin
          if (cur == s_cell) begin
            stored_len <= plen;
            state <= S_RESP;
          end else begin
            state <= S_TR_WAIT;
          end
        end
        S_TR_WAIT: begin
          plen <= plen + LenW'(1);
          cur <= par;
          if (plen == LenW'(Cells - 1)) begin
            stored_len <= LenW'(Cells);
            state <= S_RESP;
          end else begin
            state <= S_TR_RD;
          end
        end
        S_RESP: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data.found <= found_flag;
            out_data.path_length <= 11'(stored_len);
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("accept while result pending");
  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  ap_len_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.found || out_data.path_length == '0))
    else $error("path stored without found");
endmodule
